### sv/cpet_pkg.sv
// Shared types and constants for the collision pair event tracker.
// No dependencies; used by the core, the overlap unit and the checker.
package cpet_pkg;

  // Default table depth and collider id width
  localparam int PAIR_ENTRIES_DEF = 64;
  localparam int ID_BITS_DEF      = 16;

  // Fixed field widths (fixed point, 8 fraction bits)
  localparam int COORD_W = 24;            // signed center coordinate
  localparam int SIZE_W  = 23;            // unsigned full size
  localparam int DIFF_W  = COORD_W + 1;   // exact center difference
  localparam int SUM_W   = SIZE_W + 1;    // exact size sum
  localparam int CMP_W   = DIFF_W + 2;    // doubled difference with headroom

  // Contact event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } ev_t;

endpackage

### sv/cpet_overlap.sv
// Axis-aligned box overlap test: registered differences and sums, then compare.
// Depends on cpet_pkg for the coordinate widths.
module cpet_overlap (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [cpet_pkg::COORD_W-1:0]  first_x,
  input  logic signed [cpet_pkg::COORD_W-1:0]  first_y,
  input  logic        [cpet_pkg::SIZE_W-1:0]   first_w,
  input  logic        [cpet_pkg::SIZE_W-1:0]   first_h,
  input  logic signed [cpet_pkg::COORD_W-1:0]  second_x,
  input  logic signed [cpet_pkg::COORD_W-1:0]  second_y,
  input  logic        [cpet_pkg::SIZE_W-1:0]   second_w,
  input  logic        [cpet_pkg::SIZE_W-1:0]   second_h,
  output logic                                 overlap
);

  logic signed [cpet_pkg::DIFF_W-1:0] dx_r;
  logic signed [cpet_pkg::DIFF_W-1:0] dy_r;
  logic        [cpet_pkg::SUM_W-1:0]  sw_r;
  logic        [cpet_pkg::SUM_W-1:0]  sh_r;

  // 2*|d| < s  <=>  2*d < s and -2*d < s; both compares run side by side
  function automatic logic axis_hit(input logic signed [cpet_pkg::DIFF_W-1:0] d,
                                    input logic        [cpet_pkg::SUM_W-1:0]  s);
    logic signed [cpet_pkg::CMP_W-1:0] d2;
    logic signed [cpet_pkg::CMP_W-1:0] sc;
    d2 = cpet_pkg::CMP_W'(d) <<< 1;
    sc = signed'(cpet_pkg::CMP_W'(s));
    return (d2 < sc) && ((-d2) < sc);
  endfunction

  // Exact differences and sums, captured with the beat
  always_ff @(posedge clk) begin
    if (load) begin
      dx_r <= cpet_pkg::DIFF_W'(first_x) - cpet_pkg::DIFF_W'(second_x);
      dy_r <= cpet_pkg::DIFF_W'(first_y) - cpet_pkg::DIFF_W'(second_y);
      sw_r <= cpet_pkg::SUM_W'(first_w) + cpet_pkg::SUM_W'(second_w);
      sh_r <= cpet_pkg::SUM_W'(first_h) + cpet_pkg::SUM_W'(second_h);
    end
  end

  assign overlap = axis_hit(dx_r, sw_r) && axis_hit(dy_r, sh_r);

endmodule

### sv/collision_pair_event_tracker_core.sv
// Collision pair event tracker: pair table memory, search sequencer, result register.
// Depends on cpet_pkg and cpet_overlap.
//
// Each input beat either checks an ordered collider pair or clears the pair
// table, and gives exactly one result beat. A check searches the table one
// entry per cycle through the single read port of the pair memory, stopping at
// the matching entry or at the last stored pair: an item passes PREP, SCAN
// (skipped on an empty table) and FIN before the next accept; a clear goes
// straight to FIN. The table has no clearing pass: a fill count marks the live
// entries, so reset and clear take effect at once. An unseen pair is appended
// while room is left; otherwise table_full is set in its result. The result
// register frees the input side as soon as the result is written into it.
module collision_pair_event_tracker_core #(
  parameter int PAIR_ENTRIES = cpet_pkg::PAIR_ENTRIES_DEF,
  parameter int ID_BITS      = cpet_pkg::ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic        [ID_BITS-1:0]           in_first_id,
  input  logic        [ID_BITS-1:0]           in_second_id,
  input  logic signed [cpet_pkg::COORD_W-1:0] in_first_x,
  input  logic signed [cpet_pkg::COORD_W-1:0] in_first_y,
  input  logic        [cpet_pkg::SIZE_W-1:0]  in_first_w,
  input  logic        [cpet_pkg::SIZE_W-1:0]  in_first_h,
  input  logic signed [cpet_pkg::COORD_W-1:0] in_second_x,
  input  logic signed [cpet_pkg::COORD_W-1:0] in_second_y,
  input  logic        [cpet_pkg::SIZE_W-1:0]  in_second_w,
  input  logic        [cpet_pkg::SIZE_W-1:0]  in_second_h,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [1:0]                   out_contact_event,
  output logic                                out_overlapping,
  output logic                                out_table_full
);

  localparam int KW = 2 * ID_BITS;                  // pair key width
  localparam int AW = $clog2(PAIR_ENTRIES);         // table index width
  localparam int CW = $clog2(PAIR_ENTRIES + 1);     // fill count width

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;

  // pair table: {touching, key}
  logic [KW:0]    pair_mem [PAIR_ENTRIES];
  logic [KW:0]    rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;

  logic [CW-1:0]  used_r;
  logic [AW-1:0]  scan_idx_r;
  logic           clr_r;
  logic [KW-1:0]  key_r;
  logic           hit_r;
  logic [AW-1:0]  slot_r;
  logic           prev_r;

  logic           out_valid_r;
  cpet_pkg::ev_t  out_event_r;
  logic           out_ovl_r;
  logic           out_full_r;

  logic           in_acc;
  logic           out_free;
  logic           fin_done;
  logic           key_match;
  logic           scan_last;
  logic           room;
  logic           ovl;
  cpet_pkg::ev_t  ev;

  // Box test unit, loaded with the accepted beat
  cpet_overlap u_ovl (
    .clk      (clk),
    .load     (in_acc),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .first_w  (in_first_w),
    .first_h  (in_first_h),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .second_w (in_second_w),
    .second_h (in_second_h),
    .overlap  (ovl)
  );

  // Handshake and search status
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign fin_done  = (state_r == ST_FIN) && out_free;
  assign key_match = (rd_data_r[KW-1:0] == key_r);
  assign scan_last = ((CW'(scan_idx_r) + CW'(1)) == used_r);
  assign room      = (used_r < CW'(PAIR_ENTRIES));

  // Read address runs one ahead of the compared entry
  assign rd_addr   = (state_r == ST_SCAN) ? (scan_idx_r + AW'(1)) : '0;

  // Writes happen only in FIN
  assign mem_we    = fin_done && !clr_r && (hit_r || room);
  assign mem_waddr = hit_r ? slot_r : used_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_mem[mem_waddr] <= {ovl, key_r};
    end
    rd_data_r <= pair_mem[rd_addr];
  end

  // Event from previous touching flag and current overlap
  always_comb begin
    if (ovl) begin
      ev = (hit_r && prev_r) ? cpet_pkg::EV_STAY : cpet_pkg::EV_ENTER;
    end else begin
      ev = (hit_r && prev_r) ? cpet_pkg::EV_EXIT : cpet_pkg::EV_NONE;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_req_type ? ST_FIN : ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = (used_r == '0) ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (key_match || scan_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_done) begin
        if (clr_r) begin
          used_r <= '0;
        end else if (!hit_r && room) begin
          used_r <= used_r + CW'(1);
        end
      end
    end
  end

  // Request and search payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      clr_r <= in_req_type;
      key_r <= {in_first_id, in_second_id};
    end
    if (state_r == ST_PREP) begin
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
      prev_r     <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      scan_idx_r <= scan_idx_r + AW'(1);
      if (key_match) begin
        hit_r  <= 1'b1;
        slot_r <= scan_idx_r;
        prev_r <= rd_data_r[KW];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fin_done) begin
      if (clr_r) begin
        out_event_r <= cpet_pkg::EV_NONE;
        out_ovl_r   <= 1'b0;
        out_full_r  <= 1'b0;
      end else begin
        out_event_r <= ev;
        out_ovl_r   <= ovl;
        out_full_r  <= !hit_r && !room;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_contact_event = out_event_r;
  assign out_overlapping   = out_ovl_r;
  assign out_table_full    = out_full_r;

endmodule

### sv/cpet_checker.sv
// Port-level checker for the collision pair event tracker, bound to the core.
// Depends on cpet_pkg for the event codes.
module cpet_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_contact_event,
  input logic       out_overlapping,
  input logic       out_table_full
);

  // Result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_contact_event)
      && $stable(out_overlapping) && $stable(out_table_full))
    else $error("result beat changed while stalled");

  // No result right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Enter and stay need overlap
  a_touch_ovl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_contact_event == cpet_pkg::EV_ENTER ||
                  out_contact_event == cpet_pkg::EV_STAY) |-> out_overlapping)
    else $error("enter or stay without overlap");

  // None and exit mean no overlap
  a_free_ovl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_contact_event == cpet_pkg::EV_NONE ||
                  out_contact_event == cpet_pkg::EV_EXIT) |-> !out_overlapping)
    else $error("none or exit with overlap");

  // An unstored pair had no previous contact
  a_full_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> (out_contact_event == cpet_pkg::EV_NONE ||
                                     out_contact_event == cpet_pkg::EV_ENTER))
    else $error("stay or exit reported for an unstored pair");

endmodule

bind collision_pair_event_tracker_core cpet_checker u_cpet_checker (.*);
